@@ design/plic_pkg.sv @@
package plic_pkg;

  localparam int NUM_SOURCES_DEF   = 64;
  localparam int NUM_CONTEXTS_DEF  = 2;
  localparam int PRIORITY_BITS_DEF = 3;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  localparam logic [25:0] PENDING_BASE = 26'h0001000;
  localparam logic [25:0] ENABLE_BASE  = 26'h0002000;
  localparam logic [25:0] CTXCTL_BASE  = 26'h0200000;

  localparam logic [9:0] CTL_THRESHOLD = 10'd0;
  localparam logic [9:0] CTL_CLAIM     = 10'd1;

endpackage

@@ design/platform_interrupt_controller.sv @@
// channel  | handshake             | payload
// in       | in_valid / in_ready   | opcode, reg_offset, write_value, source_id
// out      | out_valid / out_ready | read_value, irq_lines
//
// every item ends with one pass over sources 1..NUM_SOURCES-1 through the priority
// and enable memories, one source per cycle; a priority or enable read or a complete
// write first passes through an access state
// a claim read makes two passes (claim, then irq lines)
// after reset a clearing pass zeroes both memories, in_ready low
// a finished result waits in the output register while the next item is taken; a
// result still held there by out_ready low stalls the end of the next scan
module platform_interrupt_controller #(
  parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [25:0] reg_offset,
  input  logic [31:0] write_value,
  input  logic [5:0]  source_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [1:0]  irq_lines
);
  import plic_pkg::*;

  localparam int SW    = $clog2(NUM_SOURCES);
  localparam int WORDS = NUM_SOURCES / 32;
  localparam int ENW   = NUM_CONTEXTS * WORDS;
  localparam int EW    = (ENW > 1) ? $clog2(ENW) : 1;
  localparam int CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int PW    = PRIORITY_BITS;
  localparam logic [31:0] PRIO_MAX = 32'((1 << PRIORITY_BITS) - 1);
  localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);
  localparam logic [CW-1:0] CTX_B = (NUM_CONTEXTS > 1) ? CW'(1) : CW'(0);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_ACCESS = 5'b01000,
    S_SCAN   = 5'b10000
  } state_t;

  state_t state;
  logic   finish;

  // memories
  logic [PW-1:0] prio_mem [NUM_SOURCES];
  logic [31:0]   en_mem [ENW];
  logic          prio_we, en_we;
  logic [SW-1:0] prio_wa, prio_ra;
  logic [PW-1:0] prio_wd, prio_q;
  logic [EW-1:0] en_wa, en_ra_a, en_ra_b;
  logic [31:0]   en_wd, en_qa, en_qb;

  logic [NUM_SOURCES-1:0] pending, in_service;
  logic [PW-1:0]          thr [NUM_CONTEXTS];

  logic [1:0]  q_op;
  logic [25:0] q_off;
  logic [31:0] q_val;
  logic [5:0]  q_sid;
  logic [31:0] rd_val;
  logic [1:0]  lines;

  logic [SW-1:0] clr_cnt, scan_cnt, sd, best_a, best_b, fin_a, fin_b;
  logic          scan_issue, sd_v, claim_pass;
  logic [CW-1:0] ctx_a;
  logic [PW-1:0] bprio_a, bprio_b;
  logic          hit_a, hit_b;

  // decode of the latched access
  logic [25:0] off, en_rel, ctl_rel;
  logic        rg_prio, rg_pend, rg_en, rg_ctl;
  logic [9:0]  bus_s, pend_w, ctl_r;
  logic [4:0]  en_w;
  logic [18:0] en_c;
  logic [13:0] ctl_c;
  logic        prio_ok, pend_ok, en_ok, ctl_ok, cmp_ok, is_rd, is_wr;
  logic        thr_we, exec_access, exec_claim;
  logic [PW-1:0] thr_a0, thr_b0;

  always_comb begin
    off     = {q_off[25:2], 2'b00};
    rg_prio = off < PENDING_BASE;
    rg_pend = !rg_prio && off < ENABLE_BASE;
    rg_en   = off >= ENABLE_BASE && off < CTXCTL_BASE;
    rg_ctl  = off >= CTXCTL_BASE;
    bus_s   = off[11:2];
    pend_w  = off[11:2];
    en_rel  = off - ENABLE_BASE;
    en_c    = en_rel[25:7];
    en_w    = en_rel[6:2];
    ctl_rel = off - CTXCTL_BASE;
    ctl_c   = ctl_rel[25:12];
    ctl_r   = ctl_rel[11:2];
    prio_ok = bus_s != 10'd0 && 32'(bus_s) < 32'(NUM_SOURCES);
    pend_ok = 32'(pend_w) < 32'(WORDS);
    en_ok   = 32'(en_c) < 32'(NUM_CONTEXTS) && 32'(en_w) < 32'(WORDS);
    ctl_ok  = 32'(ctl_c) < 32'(NUM_CONTEXTS);
    cmp_ok  = q_val != 32'd0 && q_val < 32'(NUM_SOURCES);
    is_rd   = q_op == OP_READ;
    is_wr   = q_op == OP_WRITE;
    thr_we  = is_wr && rg_ctl && ctl_ok && ctl_r == CTL_THRESHOLD && q_val <= PRIO_MAX;
    exec_claim  = is_rd && rg_ctl && ctl_ok && ctl_r == CTL_CLAIM;
    exec_access = (is_rd && rg_prio && prio_ok) || (is_rd && rg_en && en_ok) ||
                  (is_wr && rg_ctl && ctl_ok && ctl_r == CTL_CLAIM && cmp_ok);
    // thresholds the irq line pass starts from, including a write in flight
    thr_a0 = (thr_we && ctl_c[CW-1:0] == CW'(0)) ? q_val[PW-1:0] : thr[0];
    thr_b0 = (thr_we && ctl_c[CW-1:0] == CTX_B) ? q_val[PW-1:0] : thr[CTX_B];
  end

  // memory port control
  always_comb begin
    prio_we = 1'b0;
    prio_wa = bus_s[SW-1:0];
    prio_wd = q_val[PW-1:0];
    en_we   = 1'b0;
    en_wa   = EW'(32'(en_c[CW-1:0]) * WORDS + 32'(en_w));
    en_wd   = (en_w == 5'd0) ? (q_val & ~32'd1) : q_val;
    if (state == S_CLEAR) begin
      prio_we = 1'b1;
      prio_wa = clr_cnt;
      prio_wd = '0;
      en_we   = 32'(clr_cnt) < 32'(ENW);
      en_wa   = clr_cnt[EW-1:0];
      en_wd   = '0;
    end else if (state == S_EXEC && is_wr) begin
      prio_we = rg_prio && prio_ok && q_val <= PRIO_MAX;
      en_we   = rg_en && en_ok;
    end
    if (state == S_SCAN) begin
      prio_ra = scan_cnt;
      en_ra_a = EW'(32'(ctx_a) * WORDS + 32'(scan_cnt >> 5));
      en_ra_b = EW'(32'(CTX_B) * WORDS + 32'(scan_cnt >> 5));
    end else begin
      prio_ra = bus_s[SW-1:0];
      en_ra_b = '0;
      if (rg_en)
        en_ra_a = EW'(32'(en_c[CW-1:0]) * WORDS + 32'(en_w));
      else
        en_ra_a = EW'(32'(ctl_c[CW-1:0]) * WORDS + 32'(q_val[SW-1:0] >> 5));
    end
  end

  always_ff @(posedge clk) begin
    if (prio_we) prio_mem[prio_wa] <= prio_wd;
    prio_q <= prio_mem[prio_ra];
  end

  always_ff @(posedge clk) begin
    if (en_we) en_mem[en_wa] <= en_wd;
    en_qa <= en_mem[en_ra_a];
    en_qb <= en_mem[en_ra_b];
  end

  // compare stage of the scan
  always_comb begin
    hit_a = sd_v && pending[sd] && en_qa[sd[4:0]] && prio_q > bprio_a;
    hit_b = sd_v && pending[sd] && en_qb[sd[4:0]] && prio_q > bprio_b;
    fin_a = hit_a ? sd : best_a;
    fin_b = hit_b ? sd : best_b;
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      pending    <= '0;
      in_service <= '0;
      out_valid  <= 1'b0;
      finish     <= 1'b0;
      scan_issue <= 1'b0;
      sd_v       <= 1'b0;
      claim_pass <= 1'b0;
      for (int c = 0; c < NUM_CONTEXTS; c++) thr[c] <= '0;
    end else begin
      if (finish && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        read_value <= rd_val;
        irq_lines  <= lines;
        finish     <= 1'b0;
        state      <= S_IDLE;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_cnt == LAST_SRC) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            q_op   <= opcode;
            q_off  <= reg_offset;
            q_val  <= write_value;
            q_sid  <= source_id;
            rd_val <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= exec_access ? S_ACCESS : S_SCAN;
          claim_pass <= exec_claim;
          ctx_a      <= exec_claim ? ctl_c[CW-1:0] : CW'(0);
          bprio_a    <= exec_claim ? thr[ctl_c[CW-1:0]] : thr_a0;
          bprio_b    <= thr_b0;
          best_a     <= '0;
          best_b     <= '0;
          scan_cnt   <= SW'(1);
          scan_issue <= 1'b1;
          sd_v       <= 1'b0;
          if (q_op == OP_REQUEST) begin
            if (q_sid != 6'd0 && 32'(q_sid) < 32'(NUM_SOURCES) &&
                !pending[q_sid] && !in_service[q_sid])
              pending[q_sid] <= 1'b1;
          end else if (is_rd && rg_pend && pend_ok) begin
            rd_val <= pending[32*int'(pend_w) +: 32];
          end else if (rg_ctl && ctl_ok && ctl_r == CTL_THRESHOLD) begin
            if (is_rd) rd_val <= 32'(thr[ctl_c[CW-1:0]]);
            else if (thr_we) thr[ctl_c[CW-1:0]] <= q_val[PW-1:0];
          end
        end
        S_ACCESS: begin
          if (rg_prio) rd_val <= 32'(prio_q);
          else if (rg_en) rd_val <= en_qa;
          else if (en_qa[q_val[4:0]]) in_service[q_val[SW-1:0]] <= 1'b0;
          state      <= S_SCAN;
          claim_pass <= 1'b0;
          ctx_a      <= '0;
          bprio_a    <= thr[0];
          bprio_b    <= thr[CTX_B];
          best_a     <= '0;
          best_b     <= '0;
          scan_cnt   <= SW'(1);
          scan_issue <= 1'b1;
          sd_v       <= 1'b0;
        end
        S_SCAN: begin
          if (!finish) begin
            sd_v <= scan_issue;
            if (scan_issue) begin
              sd <= scan_cnt;
              if (scan_cnt == LAST_SRC) scan_issue <= 1'b0;
              else scan_cnt <= scan_cnt + SW'(1);
            end
            if (sd_v && sd == LAST_SRC) begin
              if (claim_pass) begin
                if (fin_a != '0) begin
                  pending[fin_a]    <= 1'b0;
                  in_service[fin_a] <= 1'b1;
                  rd_val            <= 32'(fin_a);
                end
                // second pass for the irq lines
                claim_pass <= 1'b0;
                ctx_a      <= '0;
                bprio_a    <= thr[0];
                bprio_b    <= thr[CTX_B];
                best_a     <= '0;
                best_b     <= '0;
                scan_cnt   <= SW'(1);
                scan_issue <= 1'b1;
              end else begin
                lines  <= {NUM_CONTEXTS > 1 && fin_b != '0, fin_a != '0};
                finish <= 1'b1;
              end
            end else begin
              if (hit_a) begin
                best_a  <= sd;
                bprio_a <= prio_q;
              end
              if (hit_b) begin
                best_b  <= sd;
                bprio_b <= prio_q;
              end
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

@@ dv/tb_platform_interrupt_controller.sv @@
module tb_platform_interrupt_controller;
  import plic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSRC = NUM_SOURCES_DEF;
  localparam int NCTX = NUM_CONTEXTS_DEF;
  localparam int WPC = NSRC / 32;
  localparam logic [31:0] LVL_MAX = (1 << PRIORITY_BITS_DEF) - 1;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [25:0] offs;
    logic [31:0] wdata;
    logic [5:0]  sid;
  } bus_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  lines;
  } plic_result_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] opcode;
  logic [25:0] reg_offset;
  logic [31:0] write_value;
  logic [5:0] source_id;
  logic [31:0] read_value;
  logic [1:0] irq_lines;

  platform_interrupt_controller dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .reg_offset(reg_offset), .write_value(write_value),
    .source_id(source_id), .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .irq_lines(irq_lines)
  );

  logic [2:0]  prio_m [NSRC];
  logic        pend_m [NSRC];
  logic        insvc_m [NSRC];
  logic [31:0] en_m [NCTX*WPC];
  logic [2:0]  thr_m [NCTX];

  bus_item_t    pending_items[$];
  plic_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0, out_gap = 0;
  bit stim_done = 0;
  bit in_acc = 0;

  function automatic bit src_enabled(int c, int s);
    return en_m[c*WPC + s/32][s%32];
  endfunction

  function automatic int winning_source(int c);
    int best, lvl;
    best = 0;
    lvl = thr_m[c];
    for (int s = 1; s < NSRC; s++)
      if (pend_m[s] && src_enabled(c, s) && prio_m[s] > lvl) begin
        best = s;
        lvl = prio_m[s];
      end
    return best;
  endfunction

  function automatic logic [31:0] plic_access(bit wr, logic [25:0] off, logic [31:0] v);
    logic [31:0] rd;
    int s, w, c, r;
    rd = '0;
    if (off < PENDING_BASE) begin
      s = off >> 2;
      if (s != 0 && s < NSRC) begin
        if (wr) begin
          if (v <= LVL_MAX) prio_m[s] = v[2:0];
        end else rd = 32'(prio_m[s]);
      end
    end else if (off < ENABLE_BASE) begin
      w = (off - PENDING_BASE) >> 2;
      if (!wr && w < WPC)
        for (int b = 0; b < 32; b++) rd[b] = pend_m[w*32 + b];
    end else if (off < CTXCTL_BASE) begin
      c = (off - ENABLE_BASE) >> 7;
      w = ((off - ENABLE_BASE) >> 2) & 31;
      if (c < NCTX && w < WPC) begin
        if (wr) en_m[c*WPC + w] = (w == 0) ? (v & ~32'd1) : v;
        else rd = en_m[c*WPC + w];
      end
    end else begin
      c = (off - CTXCTL_BASE) >> 12;
      r = ((off - CTXCTL_BASE) >> 2) & 10'h3ff;
      if (c < NCTX) begin
        if (r == CTL_THRESHOLD) begin
          if (wr) begin
            if (v <= LVL_MAX) thr_m[c] = v[2:0];
          end else rd = 32'(thr_m[c]);
        end else if (r == CTL_CLAIM) begin
          if (wr) begin
            if (v != 0 && v < NSRC && src_enabled(c, v)) insvc_m[v] = 0;
          end else begin
            rd = winning_source(c);
            if (rd != 0) begin
              pend_m[rd] = 0;
              insvc_m[rd] = 1;
            end
          end
        end
      end
    end
    return wr ? 32'd0 : rd;
  endfunction

  function automatic plic_result_t plic_predict(bus_item_t it);
    plic_result_t res;
    logic [25:0] off;
    off = it.offs & ~26'd3;
    res = '0;
    if (it.op == OP_READ || it.op == OP_WRITE)
      res.rdata = plic_access(it.op == OP_WRITE, off, it.wdata);
    else if (it.op == OP_REQUEST) begin
      if (it.sid != 0 && it.sid < NSRC && !pend_m[it.sid] && !insvc_m[it.sid])
        pend_m[it.sid] = 1;
    end
    for (int c = 0; c < NCTX && c < 2; c++)
      if (winning_source(c) != 0) res.lines[c] = 1'b1;
    return res;
  endfunction

  function automatic int draw_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_acc) in_gap = draw_gap();
      if (in_valid && !in_acc) begin
        // hold until transfer
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (pending_items.size() > 0) begin
        opcode <= pending_items[0].op;
        reg_offset <= pending_items[0].offs;
        write_value <= pending_items[0].wdata;
        source_id <= pending_items[0].sid;
        in_valid <= 1;
        void'(pending_items.pop_front());
      end else begin
        in_valid <= 0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        out_gap = draw_gap();
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    plic_result_t got, want;
    if (rst) begin
      idle_cycles <= 0;
      in_acc = 0;
    end else begin
      in_acc = in_valid && in_ready;
      if (in_valid && in_ready)
        expected_results.push_back(plic_predict({opcode, reg_offset, write_value, source_id}));
      if (out_valid && out_ready) begin
        got = {read_value, irq_lines};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result rd=%h irq=%b", read_value, irq_lines);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: rd exp %h got %h, irq exp %b got %b",
                       want.rdata, got.rdata, want.lines, got.lines);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [25:0] off, logic [31:0] v, logic [5:0] s);
    pending_items.push_back({op, off, v, s});
  endtask

  function automatic logic [31:0] rand_level();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, LVL_MAX + 1);
  endfunction

  function automatic logic [25:0] rand_offset();
    int c;
    c = $urandom_range(0, NCTX);
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, NSRC) << 2;
      2: return PENDING_BASE + ($urandom_range(0, WPC) << 2) + $urandom_range(0, 3);
      3, 4: return ENABLE_BASE + (c << 7) + ($urandom_range(0, WPC) << 2);
      5: return CTXCTL_BASE + (c << 12);
      6, 7, 8: return CTXCTL_BASE + (c << 12) + 4 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [1:0] op;
    int c;
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    opcode = '0;
    reg_offset = '0;
    write_value = '0;
    source_id = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: source zero, too-large levels, unmapped, pending write, claims
    push_item(OP_WRITE, 26'h0, 32'd5, 6'd0);
    push_item(OP_READ, 26'h0, 32'd0, 6'd0);
    push_item(OP_WRITE, 26'h4, 32'd7, 6'd0);
    push_item(OP_WRITE, 26'h8, 32'd8, 6'd0);
    push_item(OP_WRITE, 26'hfc, 32'd7, 6'd0);
    push_item(OP_WRITE, ENABLE_BASE, 32'hffff_ffff, 6'd0);
    push_item(OP_WRITE, ENABLE_BASE + 4, 32'hffff_ffff, 6'd0);
    push_item(OP_WRITE, ENABLE_BASE + 26'h80, 32'h0000_0006, 6'd0);
    push_item(OP_REQUEST, 26'h0, 32'd0, 6'd0);
    push_item(OP_REQUEST, 26'h0, 32'd0, 6'd1);
    push_item(OP_REQUEST, 26'h0, 32'd0, 6'd63);
    push_item(OP_REQUEST, 26'h0, 32'd0, 6'd1);
    push_item(OP_READ, PENDING_BASE, 32'd0, 6'd0);
    push_item(OP_WRITE, PENDING_BASE, 32'hffff_ffff, 6'd0);
    push_item(OP_READ, PENDING_BASE + 4, 32'd0, 6'd0);
    push_item(OP_WRITE, CTXCTL_BASE, 32'd9, 6'd0);
    push_item(OP_WRITE, CTXCTL_BASE + 26'h1000, 32'd7, 6'd0);
    push_item(OP_READ, CTXCTL_BASE + 4, 32'd0, 6'd0);
    push_item(OP_READ, CTXCTL_BASE + 4, 32'd0, 6'd0);
    push_item(OP_WRITE, CTXCTL_BASE + 26'h1004, 32'd1, 6'd0);
    push_item(OP_WRITE, CTXCTL_BASE + 4, 32'd1, 6'd0);
    push_item(OP_WRITE, 26'h3ff_fffc, 32'hffff_ffff, 6'd0);
    push_item(OP_READ, 26'h3ff_ffff, 32'd0, 6'd0);
    push_item(OP_NOP, 26'h3ff_ffff, 32'hffff_ffff, 6'd63);
    // sender holds off until everything has come back
    wait_drained();

    for (int i = 0; i < 1630; i++) begin
      c = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: push_item(OP_REQUEST, $urandom, $urandom, $urandom);
        6, 7, 8, 9, 10: push_item(OP_READ, CTXCTL_BASE + (c << 12) + 4, $urandom, 0);
        11, 12: push_item(OP_WRITE, CTXCTL_BASE + (c << 12) + 4,
                          $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 64), 0);
        13: push_item(OP_WRITE, $urandom_range(0, NSRC) << 2, rand_level(), 0);
        14: push_item(OP_WRITE, CTXCTL_BASE + (c << 12), rand_level(), 0);
        15: push_item(OP_WRITE, ENABLE_BASE + (c << 7) + ($urandom_range(0, WPC) << 2),
                      $urandom, 0);
        16: push_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        default: begin
          op = 2'($urandom_range(0, 1));
          push_item(op, rand_offset(), $urandom_range(0, 1) ? $urandom : rand_level(),
                    $urandom);
        end
      endcase
      if (i == 800) wait_drained();
    end
    wait_drained();
    stim_done = 1;
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ platform_interrupt_controller.f @@
design/plic_pkg.sv
design/platform_interrupt_controller.sv
dv/tb_platform_interrupt_controller.sv
